@@ hw/rtl/dott_pkg.sv @@
// Shared types and constants for the deadline-ordered timer table.
// No dependencies.
package dott_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W = $clog2(NUM_TIMERS);
  localparam logic [31:0] WINDOW_RESET = 32'd3600000;
  localparam logic [63:0] ALL_ONES = '1;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_CANCEL  = 3'd1,
    CMD_REFRESH = 3'd2,
    CMD_RESET   = 3'd3,
    CMD_EXPIRE  = 3'd4,
    CMD_WAIT    = 3'd5,
    CMD_ANY     = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // candidate travelling down the cell row
  typedef struct packed {
    logic              valid;
    logic [63:0]       dl;
    logic [SLOT_W-1:0] id;
  } cand_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              set_act;
    logic              clr_act;
    logic              wr_per;
    logic              wr_dl;
    logic              wr_rep;
    logic              load_due;
    logic              clr_due;
    logic              changed;
    logic              sel_due;
    logic [63:0]       per;
    logic [63:0]       dl;
    logic              rep;
    logic [63:0]       now;
  } cell_ctl_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  result_id;
    logic        is_expiry;
    logic [63:0] wait_ms;
    logic        any_active;
    logic        became_earliest;
    logic        last;
  } rsp_t;

  function automatic rsp_t rsp_done(status_t s);
    rsp_t r;
    r = '0;
    r.status = s;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

@@ hw/rtl/dott_req_if.sv @@
// Command channel of the timer table.
// No dependencies.
interface dott_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  timer_id;
  logic [63:0] period_ms;
  logic        repeat_req;
  logic        anchor_now;
  logic [63:0] now_ms;

  modport source(output valid, cmd, timer_id, period_ms, repeat_req, anchor_now, now_ms,
                 input ready);
  modport sink(input valid, cmd, timer_id, period_ms, repeat_req, anchor_now, now_ms,
               output ready);
endinterface

@@ hw/rtl/dott_rsp_if.sv @@
// Result channel of the timer table.
// No dependencies.
interface dott_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  result_id;
  logic        is_expiry;
  logic [63:0] wait_ms;
  logic        any_active;
  logic        became_earliest;
  logic        last;

  modport source(output valid, status, result_id, is_expiry, wait_ms, any_active,
                 became_earliest, last, input ready);
  modport sink(input valid, status, result_id, is_expiry, wait_ms, any_active,
               became_earliest, last, output ready);
endinterface

@@ hw/rtl/dott_cfg_if.sv @@
// Configuration write channel (rollback window).
// No dependencies.
interface dott_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ hw/rtl/dott_cell.sv @@
// One timer slot: state, due flag and one stage of the earliest-deadline chain.
// Depends on dott_pkg.
module dott_cell import dott_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] index,
  input  cell_ctl_t         ctl,
  input  cand_t             cin,
  output cand_t             cout,
  output logic              active,
  output logic [63:0]       period,
  output logic [63:0]       deadline,
  output logic              rep,
  output logic              due
);

  logic hit;
  logic own_sel;
  logic take;

  assign hit = (ctl.slot == index);
  assign own_sel = ctl.sel_due ? due : active;
  // lower slots arrive on cin, so a tie keeps the incoming one
  assign take = own_sel && (!cin.valid || (deadline < cin.dl));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      due <= 1'b0;
      cout.valid <= 1'b0;
    end else begin
      if (hit && ctl.set_act) active <= 1'b1;
      if (hit && ctl.clr_act) active <= 1'b0;
      if (ctl.load_due) due <= active && (ctl.changed || (deadline <= ctl.now));
      if (hit && ctl.clr_due) due <= 1'b0;
      cout.valid <= cin.valid || own_sel;
      if (take) begin
        cout.dl <= deadline;
        cout.id <= index;
      end else begin
        cout.dl <= cin.dl;
        cout.id <= cin.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && ctl.wr_per) period <= ctl.per;
    if (hit && ctl.wr_dl) deadline <= ctl.dl;
    if (hit && ctl.wr_rep) rep <= ctl.rep;
  end

endmodule

@@ hw/rtl/deadline_ordered_timer_table.sv @@
// Deadline-ordered timer table: sequencer, output register and the row of slot cells.
// Add, reset, wait query and expire may scan the slot chain before their result; other
// commands skip the scan. Reset from the old start first passes through S_RST2.
// One command at a time; each further expiry runs another scan, and a result beat held
// by the sink stalls the sequencer.
// Reset (rst, sync): slots inactive, window 3600000, previous time 0. Uses dott_pkg, dott_cell.
module deadline_ordered_timer_table import dott_pkg::*; (
  input logic        clk,
  input logic        rst,
  dott_req_if.sink   req,
  dott_rsp_if.source rsp,
  dott_cfg_if.sink   cfg
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_RST2 = 6'b000100,
    S_SCAN = 6'b001000,
    S_POST = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t st, st_next;

  logic [31:0]       window;
  logic [63:0]       prev_time;
  logic              fn;
  cmd_t              c_cmd;
  logic [3:0]        c_id;
  logic [63:0]       c_per;
  logic              c_rep;
  logic              c_fnow;
  logic [63:0]       c_now;
  logic [63:0]       start;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] cnt;
  logic              scan_due;
  logic              more;
  rsp_t              pend;
  rsp_t              o;
  logic              o_valid;

  cell_ctl_t         ctl;
  cand_t             chain [NUM_TIMERS+1];
  cand_t             best;
  logic [NUM_TIMERS-1:0] act_vec, rep_vec, due_vec, rem_due;
  logic [63:0]       per_arr [NUM_TIMERS];
  logic [63:0]       dl_arr [NUM_TIMERS];

  logic              any_act, id_ok, id_valid, free_found, front, chg;
  logic [SLOT_W-1:0] id_slot, free_slot, t;
  logic [63:0]       id_per;
  rsp_t              pend_nxt;
  logic              more_nxt, fn_set, fn_clr, prev_ld, start_ld, sdue_ld, sdue_nxt;
  logic              cur_ld;
  logic [SLOT_W-1:0] cur_nxt;

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    dott_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .index    (SLOT_W'(g)),
      .ctl      (ctl),
      .cin      (chain[g]),
      .cout     (chain[g+1]),
      .active   (act_vec[g]),
      .period   (per_arr[g]),
      .deadline (dl_arr[g]),
      .rep      (rep_vec[g]),
      .due      (due_vec[g])
    );
  end

  assign best = chain[NUM_TIMERS];
  assign t = best.id;
  assign any_act = |act_vec;
  assign id_ok = (32'(c_id) < NUM_TIMERS);
  assign id_slot = SLOT_W'(c_id);
  assign id_valid = id_ok && act_vec[id_slot];
  assign id_per = per_arr[id_slot];
  assign front = best.valid && (best.id == cur_slot) && !fn;
  assign rem_due = due_vec & ~(NUM_TIMERS'(1) << t);
  assign chg = (c_now < prev_time) && ((prev_time - c_now) > {32'd0, window});

  always_comb begin
    free_found = 1'b0;
    free_slot = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!act_vec[i]) begin
        free_found = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    ctl = '0;
    ctl.now = c_now;
    ctl.sel_due = scan_due;
    ctl.slot = id_slot;
    st_next = st;
    pend_nxt = rsp_done(ST_OK);
    more_nxt = 1'b0;
    fn_set = 1'b0;
    fn_clr = 1'b0;
    prev_ld = 1'b0;
    start_ld = 1'b0;
    sdue_ld = 1'b0;
    sdue_nxt = 1'b0;
    cur_ld = 1'b0;
    cur_nxt = id_slot;
    case (st)
      S_IDLE: begin
        if (req.valid) st_next = S_EXEC;
      end
      S_EXEC: begin
        st_next = S_EMIT;
        case (c_cmd)
          CMD_ADD: begin
            if (!free_found) begin
              pend_nxt = rsp_done(ST_FULL);
            end else begin
              ctl.slot = free_slot;
              ctl.set_act = 1'b1;
              ctl.wr_per = 1'b1;
              ctl.wr_dl = 1'b1;
              ctl.wr_rep = 1'b1;
              ctl.per = c_per;
              ctl.dl = c_now + c_per;
              ctl.rep = c_rep;
              cur_ld = 1'b1;
              cur_nxt = free_slot;
              sdue_ld = 1'b1;
              st_next = S_SCAN;
            end
          end
          CMD_CANCEL: begin
            ctl.clr_act = id_valid;
            pend_nxt = rsp_done(id_valid ? ST_OK : ST_FAIL);
          end
          CMD_REFRESH: begin
            ctl.wr_dl = id_valid;
            ctl.dl = c_now + id_per;
            pend_nxt = rsp_done(id_valid ? ST_OK : ST_FAIL);
          end
          CMD_RESET: begin
            if (id_ok && (c_per == id_per) && !c_fnow) begin
              pend_nxt = rsp_done(ST_OK);
            end else if (!id_valid) begin
              pend_nxt = rsp_done(ST_FAIL);
            end else if (c_fnow) begin
              ctl.wr_per = 1'b1;
              ctl.wr_dl = 1'b1;
              ctl.per = c_per;
              ctl.dl = c_now + c_per;
              cur_ld = 1'b1;
              sdue_ld = 1'b1;
              st_next = S_SCAN;
            end else begin
              start_ld = 1'b1;
              cur_ld = 1'b1;
              st_next = S_RST2;
            end
          end
          CMD_EXPIRE: begin
            if (any_act) begin
              prev_ld = 1'b1;
              ctl.load_due = 1'b1;
              ctl.changed = chg;
              sdue_ld = 1'b1;
              sdue_nxt = 1'b1;
              st_next = S_SCAN;
            end
          end
          CMD_WAIT: begin
            fn_clr = 1'b1;
            if (any_act) begin
              sdue_ld = 1'b1;
              st_next = S_SCAN;
            end else begin
              pend_nxt.wait_ms = ALL_ONES;
            end
          end
          CMD_ANY: begin
            pend_nxt.any_active = any_act;
          end
          default: begin
            pend_nxt = rsp_done(ST_OK);
          end
        endcase
      end
      S_RST2: begin
        ctl.slot = cur_slot;
        ctl.wr_per = 1'b1;
        ctl.wr_dl = 1'b1;
        ctl.per = c_per;
        ctl.dl = start + c_per;
        sdue_ld = 1'b1;
        st_next = S_SCAN;
      end
      S_SCAN: begin
        if (cnt == SLOT_W'(NUM_TIMERS - 1)) st_next = S_POST;
      end
      S_POST: begin
        st_next = S_EMIT;
        case (c_cmd)
          CMD_EXPIRE: begin
            if (best.valid) begin
              ctl.slot = t;
              ctl.clr_due = 1'b1;
              ctl.wr_dl = rep_vec[t];
              ctl.clr_act = !rep_vec[t];
              ctl.dl = c_now + per_arr[t];
              pend_nxt.is_expiry = 1'b1;
              pend_nxt.result_id = 4'(t);
              pend_nxt.last = (rem_due == '0);
              more_nxt = (rem_due != '0);
            end
          end
          CMD_WAIT: begin
            pend_nxt.wait_ms = (c_now >= best.dl) ? 64'd0 : (best.dl - c_now);
          end
          default: begin
            fn_set = front;
            pend_nxt.became_earliest = front;
            if (c_cmd == CMD_ADD) pend_nxt.result_id = 4'(cur_slot);
          end
        endcase
      end
      S_EMIT: begin
        if (!o_valid || rsp.ready) st_next = more ? S_SCAN : S_IDLE;
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      window <= WINDOW_RESET;
      prev_time <= '0;
      fn <= 1'b0;
      o_valid <= 1'b0;
      more <= 1'b0;
      scan_due <= 1'b0;
      cnt <= '0;
    end else begin
      st <= st_next;
      if (cfg.valid && cfg.ready) window <= cfg.data;
      if (prev_ld) prev_time <= c_now;
      if (fn_clr) fn <= 1'b0;
      if (fn_set) fn <= 1'b1;
      if (sdue_ld) scan_due <= sdue_nxt;
      if (st != S_EMIT && st_next == S_EMIT) more <= more_nxt;
      if (st_next == S_SCAN && st != S_SCAN) cnt <= '0;
      else if (st == S_SCAN) cnt <= cnt + 1'b1;
      if (st == S_EMIT && (!o_valid || rsp.ready)) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      c_cmd <= cmd_t'(req.cmd);
      c_id <= req.timer_id;
      c_per <= req.period_ms;
      c_rep <= req.repeat_req;
      c_fnow <= req.anchor_now;
      c_now <= req.now_ms;
    end
    if (start_ld) start <= dl_arr[id_slot] - id_per;
    if (cur_ld) cur_slot <= cur_nxt;
    if (st != S_EMIT && st_next == S_EMIT) pend <= pend_nxt;
    if (st == S_EMIT && (!o_valid || rsp.ready)) o <= pend;
  end

  assign req.ready = (st == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = o_valid;
  assign rsp.status = o.status;
  assign rsp.result_id = o.result_id;
  assign rsp.is_expiry = o.is_expiry;
  assign rsp.wait_ms = o.wait_ms;
  assign rsp.any_active = o.any_active;
  assign rsp.became_earliest = o.became_earliest;
  assign rsp.last = o.last;

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> st == S_EXEC)
    else $error("accepted beat did not start execution");
  a_due_active: assert property (@(posedge clk) disable iff (rst)
    (due_vec & ~act_vec) == '0)
    else $error("due flag on an inactive slot");
  a_best_active: assert property (@(posedge clk) disable iff (rst)
    st == S_POST && best.valid && !scan_due |-> act_vec[best.id])
    else $error("chain picked an inactive slot");
  a_best_due: assert property (@(posedge clk) disable iff (rst)
    st == S_POST && best.valid && scan_due |-> due_vec[best.id])
    else $error("chain picked a slot that is not due");
`endif

endmodule
